// ===== src/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg: shared types, constants and functions of the scratchpad checker
// Holds the scratchpad byte map, the CRC-8 step, resolution masks and the
// item structs passed between the input register, core and output register.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // number of sensors on the bus (1 to 16)
  localparam int SENSOR_COUNT = 16;

  localparam int SENSOR_W = 4;
  localparam int TEMP_W   = 16;
  localparam int MASK_W   = 16;
  localparam int POS_W    = 4;

  // sensor index of the final sensor of a scan
  localparam logic [SENSOR_W-1:0] LAST_INDEX = SENSOR_W'(SENSOR_COUNT - 1);

  // scratchpad byte map
  localparam logic [POS_W-1:0] POS_TEMP_LSB = 4'd0;
  localparam logic [POS_W-1:0] POS_TEMP_MSB = 4'd1;
  localparam logic [POS_W-1:0] POS_CONFIG   = 4'd4;
  localparam logic [POS_W-1:0] POS_CRC      = 4'd8;

  // dallas/maxim crc-8, reflected polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // reading substituted on a crc failure (-99.0 C)
  localparam logic [TEMP_W-1:0] BAD_READING_RAW = 16'hF9D0;

  // resolution codes from config byte bits 6:5
  localparam logic [1:0] RES_9BIT  = 2'd0;
  localparam logic [1:0] RES_10BIT = 2'd1;
  localparam logic [1:0] RES_11BIT = 2'd2;
  localparam logic [1:0] RES_12BIT = 2'd3;

  typedef struct packed {
    logic       new_scan;
    logic [7:0] scratch_byte;
  } in_item_t;

  typedef struct packed {
    logic [SENSOR_W-1:0]      sensor_index;
    logic signed [TEMP_W-1:0] temp_sixteenths;
    logic                     crc_bad;
    logic [MASK_W-1:0]        error_mask;
    logic                     last_sensor;
  } result_t;

  // one byte through the crc, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ data[k];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  // clear the undefined low bits for the configured resolution
  function automatic logic [TEMP_W-1:0] apply_resolution(input logic [TEMP_W-1:0] raw,
                                                         input logic [1:0] res);
    logic [TEMP_W-1:0] masked;
    unique case (res)
      RES_9BIT:  masked = {raw[TEMP_W-1:3], 3'b000};
      RES_10BIT: masked = {raw[TEMP_W-1:2], 2'b00};
      RES_11BIT: masked = {raw[TEMP_W-1:1], 1'b0};
      RES_12BIT: masked = raw;
      default:   masked = raw;
    endcase
    return masked;
  endfunction

endpackage

// ===== src/tsc_in_reg.sv =====
// ----------------------------------------------------------------------------
// tsc_in_reg: input register of the scratchpad checker
// Captures one byte transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tsc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsc_pkg::in_item_t in_item,
  output logic              item_valid,
  output tsc_pkg::in_item_t item,
  input  logic              item_take
);
  import tsc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // free slot, or the held item leaves this cycle
  assign in_ready  = !valid_r || item_take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (item_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/tsc_core.sv =====
// ----------------------------------------------------------------------------
// tsc_core: per-sensor state and result logic
// Tracks byte position, crc and captured bytes; on the crc byte it forms the
// checked, resolution-masked reading and updates the error mask.
// ----------------------------------------------------------------------------
module tsc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  tsc_pkg::in_item_t item,
  input  logic              out_free,
  output logic              item_take,
  output logic              res_valid,
  output tsc_pkg::result_t  res
);
  import tsc_pkg::*;

  logic [POS_W-1:0]    byte_pos_r, byte_pos_nxt;
  logic [7:0]          crc_r, crc_nxt;
  logic [SENSOR_W-1:0] sensor_r, sensor_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic [7:0]          temp_lo_r;
  logic [7:0]          temp_hi_r;
  logic [1:0]          res_bits_r;

  logic [POS_W-1:0]    pos_eff;
  logic [7:0]          crc_eff;
  logic [SENSOR_W-1:0] sensor_eff;
  logic [MASK_W-1:0]   mask_eff;
  logic                emits;
  logic                crc_bad;
  logic                last;
  logic [MASK_W-1:0]   mask_upd;
  logic [TEMP_W-1:0]   raw;

  // a new scan clears position, crc, sensor and mask before this byte
  always_comb begin
    pos_eff    = item.new_scan ? '0 : byte_pos_r;
    crc_eff    = item.new_scan ? '0 : crc_r;
    sensor_eff = item.new_scan ? '0 : sensor_r;
    mask_eff   = item.new_scan ? '0 : mask_r;
  end

  // result of the crc byte
  always_comb begin
    emits    = !(pos_eff < POS_CRC);
    crc_bad  = (crc_eff != item.scratch_byte);
    last     = (sensor_eff == LAST_INDEX);
    mask_upd = mask_eff | (crc_bad ? (MASK_W'(1) << sensor_eff) : '0);
    raw      = crc_bad ? BAD_READING_RAW : {temp_hi_r, temp_lo_r};
  end

  assign item_take = item_valid && (!emits || out_free);
  assign res_valid = item_valid && emits;

  always_comb begin
    res.sensor_index    = sensor_eff;
    res.temp_sixteenths = apply_resolution(raw, res_bits_r);
    res.crc_bad         = crc_bad;
    res.error_mask      = mask_upd;
    res.last_sensor     = last;
  end

  // control state update
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    crc_nxt      = crc_r;
    sensor_nxt   = sensor_r;
    mask_nxt     = mask_r;
    if (item_take) begin
      if (!emits) begin
        byte_pos_nxt = pos_eff + POS_W'(1);
        crc_nxt      = crc8_update(crc_eff, item.scratch_byte);
        sensor_nxt   = sensor_eff;
        mask_nxt     = mask_eff;
      end else begin
        byte_pos_nxt = '0;
        crc_nxt      = '0;
        sensor_nxt   = last ? '0 : sensor_eff + SENSOR_W'(1);
        mask_nxt     = mask_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      crc_r      <= '0;
      sensor_r   <= '0;
      mask_r     <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      crc_r      <= crc_nxt;
      sensor_r   <= sensor_nxt;
      mask_r     <= mask_nxt;
    end
  end

  // captured reading and resolution bytes
  always_ff @(posedge clk) begin
    if (item_take && !emits) begin
      if (pos_eff == POS_TEMP_LSB) begin
        temp_lo_r <= item.scratch_byte;
      end
      if (pos_eff == POS_TEMP_MSB) begin
        temp_hi_r <= item.scratch_byte;
      end
      if (pos_eff == POS_CONFIG) begin
        res_bits_r <= item.scratch_byte[6:5];
      end
    end
  end

`ifndef SYNTHESIS
  // position never runs past the crc byte
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(byte_pos_r > POS_CRC))
    else $error("byte position past crc byte");

  // a delivered crc byte restarts the next sensor at byte 0
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && emits) |=> (byte_pos_r == '0 && crc_r == '0))
    else $error("position not restarted after crc byte");

  // mask only gains bits within a scan
  a_mask_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && !item.new_scan) |=> ((mask_r & $past(mask_r)) == $past(mask_r)))
    else $error("error mask lost a bit within a scan");

  // a result is only held back when the output side is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !item_take) |-> (emits && !out_free))
    else $error("item stalled without a full output");
`endif

endmodule

// ===== src/tsc_out_reg.sv =====
// ----------------------------------------------------------------------------
// tsc_out_reg: result register of the scratchpad checker
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tsc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  tsc_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output tsc_pkg::result_t out_res
);
  import tsc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  logic    load;

  // slot empty, or the held result is taken this cycle
  assign out_free  = !valid_r || out_ready;
  assign load      = res_valid && out_free;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/temp_scratchpad_checker.sv =====
// ----------------------------------------------------------------------------
// temp_scratchpad_checker: crc check and decode of sensor scratchpads
// Takes nine scratchpad bytes per sensor, checks crc-8 and emits the reading.
// ----------------------------------------------------------------------------
// Send the nine scratchpad bytes of each sensor in order, one byte per
// transfer, with in_tuser high on the first byte of a scan. The block takes
// one byte every cycle while no crc byte is held back. A byte is captured in
// the input register, then the crc and decode logic loads the result
// register from it; for byte 8 of a sensor this raises out_tvalid. A full
// result register holds back only crc bytes; other bytes keep flowing. On a
// crc failure the reading is replaced by -99.0 C and the sensor's bit is
// set in the error mask, which is kept until the next scan. Temperatures
// come as signed 1/16 C with the undefined low bits cleared per the
// resolution in byte 4; out_tlast marks the last sensor.
module temp_scratchpad_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scratch_byte
  input  logic        in_tuser,   // [0] new_scan
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] sensor_index, [19:4] temp_sixteenths,
                                  // [35:20] error_mask, [39:36] zero
  output logic        out_tuser,  // [0] crc_bad
  output logic        out_tlast   // last_sensor
);
  import tsc_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.scratch_byte = in_tdata;
  assign in_item.new_scan     = in_tuser;

  // input register
  tsc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // state and decode
  tsc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  tsc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // result packing
  assign out_tdata = {4'b0000, out_res.error_mask, out_res.temp_sixteenths,
                      out_res.sensor_index};
  assign out_tuser = out_res.crc_bad;
  assign out_tlast = out_res.last_sensor;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the scratchpad crc checker
// Feeds sensor scratchpads (good and corrupted crc, all resolutions, partial
// sensors, scans that run past the last sensor, random noise) and checks each
// reading against an in-bench decoder that follows every accepted byte.
// ----------------------------------------------------------------------------
module tb_top;
  import tsc_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_LEN    = 250;
  localparam int STREAM_BYTES = 660;

  typedef struct {
    logic [7:0] value;
    logic       scan_start;
    logic       hold_for_drain;
  } scratch_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] scratch_byte
  logic        in_tuser = 1'b0; // [0] new_scan
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [3:0] sensor_index, [19:4] temp_sixteenths,
                                // [35:20] error_mask, [39:36] zero
  logic        out_tuser;       // [0] crc_bad
  logic        out_tlast;       // last_sensor

  scratch_byte_t scratch_stream[$];
  result_t       readings_due[$];
  int            readings_outstanding = 0;
  int            bytes_sent = 0;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            stall_cycles = 0;
  int            error_count = 0;
  int            readings_checked = 0;
  int            crc_fails_seen = 0;
  int            last_sensor_seen = 0;

  // decoder state mirrored from the accepted byte stream
  logic [3:0]  scan_pos = '0;
  logic [7:0]  crc_run = '0;
  logic [7:0]  temp_lo = '0;
  logic [7:0]  temp_hi = '0;
  logic [1:0]  res_code = '0;
  logic [3:0]  sensor_num = '0;
  logic [15:0] fail_bits = '0;

  temp_scratchpad_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // byte-wise reflected crc-8: fold the byte in, then eight shifts
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // follow one accepted byte; a crc byte yields a reading
  task automatic decode_scratch_byte(input logic [7:0] b, input logic scan,
                                     output logic emit, output result_t rd);
    logic [15:0] raw;
    logic        bad;
    emit = 1'b0;
    rd   = '0;
    if (scan) begin
      scan_pos   = '0;
      crc_run    = '0;
      sensor_num = '0;
      fail_bits  = '0;
    end
    if (scan_pos < POS_CRC) begin
      if (scan_pos == POS_TEMP_LSB) begin
        temp_lo = b;
      end else if (scan_pos == POS_TEMP_MSB) begin
        temp_hi = b;
      end else if (scan_pos == POS_CONFIG) begin
        res_code = b[6:5];
      end
      crc_run  = crc8_step(crc_run, b);
      scan_pos = scan_pos + 4'd1;
    end else begin
      bad = (crc_run != b);
      if (bad) begin
        fail_bits = fail_bits | (16'd1 << sensor_num);
        raw = BAD_READING_RAW;
      end else begin
        raw = {temp_hi, temp_lo};
      end
      // drop the bits below the configured resolution
      case (res_code)
        RES_9BIT:  raw = raw & 16'hFFF8;
        RES_10BIT: raw = raw & 16'hFFFC;
        RES_11BIT: raw = raw & 16'hFFFE;
        default:   ;
      endcase
      emit               = 1'b1;
      rd.sensor_index    = sensor_num;
      rd.temp_sixteenths = raw;
      rd.crc_bad         = bad;
      rd.error_mask      = fail_bits;
      rd.last_sensor     = (sensor_num == LAST_INDEX);
      sensor_num = rd.last_sensor ? 4'd0 : sensor_num + 4'd1;
      scan_pos   = '0;
      crc_run    = '0;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, field, got, want);
    error_count++;
  endtask

  task automatic queue_byte(input logic [7:0] value, input logic scan_start,
                            input logic hold);
    scratch_byte_t sb;
    sb.value          = value;
    sb.scan_start     = scan_start;
    sb.hold_for_drain = hold;
    scratch_stream.push_back(sb);
  endtask

  // one full scratchpad, crc byte optionally corrupted
  task automatic queue_sensor(input logic [15:0] raw, input logic [7:0] cfg,
                              input logic corrupt, input logic scan_start,
                              input logic hold);
    logic [7:0] spad [0:7];
    logic [7:0] crc;
    spad[0] = raw[7:0];
    spad[1] = raw[15:8];
    spad[2] = 8'($urandom);
    spad[3] = 8'($urandom);
    spad[4] = cfg;
    spad[5] = 8'($urandom);
    spad[6] = 8'($urandom);
    spad[7] = 8'($urandom);
    crc = '0;
    for (int i = 0; i < 8; i++) begin
      crc = crc8_step(crc, spad[i]);
      queue_byte(spad[i], scan_start && (i == 0), hold && (i == 0));
    end
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    queue_byte(crc, 1'b0, 1'b0);
  endtask

  // idle mix per phase of the stream
  always_comb begin
    if (bytes_sent < PHASE_LEN) begin
      send_idle_pct = 27;
      recv_idle_pct = 54;
    end else if (bytes_sent < 2 * PHASE_LEN) begin
      send_idle_pct = 54;
      recv_idle_pct = 27;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // sender: next byte once the current transfer is done
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (scratch_stream.size() == 0 || $urandom_range(99) < send_idle_pct ||
          (scratch_stream[0].hold_for_drain && (in_tvalid || readings_outstanding != 0))) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid  <= 1'b1;
        in_tdata   <= scratch_stream[0].value;
        in_tuser   <= scratch_stream[0].scan_start;
        bytes_sent <= bytes_sent + 1;
        void'(scratch_stream.pop_front());
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    result_t got_rd;
    result_t want;
    logic    emit;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected reading", out_tdata, '0);
        end else begin
          want = readings_due.pop_front();
          readings_checked++;
          if (want.crc_bad) crc_fails_seen++;
          if (want.last_sensor) last_sensor_seen++;
          if (out_tdata[3:0] != want.sensor_index)
            report_mismatch("sensor_index", out_tdata[3:0], want.sensor_index);
          if (out_tdata[19:4] != want.temp_sixteenths)
            report_mismatch("temp_sixteenths", out_tdata[19:4], want.temp_sixteenths);
          if (out_tuser != want.crc_bad)
            report_mismatch("crc_bad", out_tuser, want.crc_bad);
          if (out_tdata[35:20] != want.error_mask)
            report_mismatch("error_mask", out_tdata[35:20], want.error_mask);
          if (out_tlast != want.last_sensor)
            report_mismatch("last_sensor", out_tlast, want.last_sensor);
          if (out_tdata[39:36] != 4'd0)
            report_mismatch("tdata padding", out_tdata[39:36], '0);
        end
      end
      if (in_tvalid && in_tready) begin
        decode_scratch_byte(in_tdata, in_tuser, emit, got_rd);
        if (emit) readings_due.push_back(got_rd);
      end
      readings_outstanding <= readings_due.size();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int   n_sens;
    logic fresh;
    logic hold;
    logic first_scan;

    // directed: broken sensor cut short by a new scan
    for (int i = 0; i < 4; i++) begin
      queue_byte(8'hFF, i == 0, 1'b0);
    end
    // zero reading at 9 bit, all-ones with bad crc at 12 bit, most negative at 10 bit
    queue_sensor(16'h0000, 8'h9F, 1'b0, 1'b1, 1'b0);
    queue_sensor(16'hFFFF, 8'h7F, 1'b1, 1'b0, 1'b0);
    queue_sensor(16'h8000, 8'h20, 1'b0, 1'b0, 1'b0);

    // random: mostly runs of whole scratchpads, some running past the last sensor, some noise
    first_scan = 1'b1;
    while (scratch_stream.size() < STREAM_BYTES) begin
      if ($urandom_range(99) < 85) begin
        n_sens = ($urandom_range(99) < 35) ? $urandom_range(16, 20) : $urandom_range(1, 15);
        fresh  = first_scan || ($urandom_range(9) != 0);
        hold   = first_scan || ($urandom_range(5) == 0);
        first_scan = 1'b0;
        for (int s = 0; s < n_sens; s++) begin
          queue_sensor(16'($urandom), 8'($urandom), $urandom_range(6) == 0,
                       fresh && (s == 0), hold && (s == 0));
        end
      end else begin
        repeat ($urandom_range(1, 12)) queue_byte(8'($urandom), $urandom_range(7) == 0, 1'b0);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (scratch_stream.size() != 0 || in_tvalid || readings_outstanding != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);

    $display("covered %0d scratchpad bytes, %0d readings checked", bytes_sent,
             readings_checked);
    $display("%0d readings with crc failure, %0d from the final sensor of a scan",
             crc_fails_seen, last_sensor_seen);
    if (error_count == 0 && readings_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
